>>> hdl/pomo_pkg.sv
// Shared types, codes and reset constants for the pomodoro phase timer.
package pomo_pkg;

   // Command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_TOGGLE = 3'd1;
   localparam logic [2:0] CMD_SKIP   = 3'd2;
   localparam logic [2:0] CMD_FINISH = 3'd3;
   localparam logic [2:0] CMD_PAUSE  = 3'd4;
   localparam logic [2:0] CMD_RESET  = 3'd5;

   // Phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_WORK  = 2'd1;
   localparam logic [1:0] PH_SHORT = 2'd2;
   localparam logic [1:0] PH_LONG  = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_WORK  = 3'd0;
   localparam logic [2:0] REG_SHORT = 3'd1;
   localparam logic [2:0] REG_LONG  = 3'd2;
   localparam logic [2:0] REG_BEEP  = 3'd3;
   localparam logic [2:0] REG_CYCLE = 3'd4;

   // Register reset values
   localparam logic [26:0] WORK_RST  = 27'd1500000;
   localparam logic [26:0] SHORT_RST = 27'd300000;
   localparam logic [26:0] LONG_RST  = 27'd900000;
   localparam logic [26:0] BEEP_RST  = 27'd3000;
   localparam logic [3:0]  CYCLE_RST = 4'd4;

   localparam logic [3:0]  CYC_MAX = 4'hF;
   localparam logic [15:0] TOT_MAX = 16'hFFFF;

   // One result item
   typedef struct packed {
      logic [1:0]  phase;
      logic        running;
      logic        beeping;
      logic [26:0] remaining_ms;
      logic [3:0]  done_in_cycle;
      logic [15:0] done_total;
      logic [31:0] alert_end_ms;
   } rsp_type;

endpackage

>>> hdl/pomo_core.sv
// Timer state, configuration registers and single-pass command update.
module pomo_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [26:0]          csr_wdata,
   input  logic                 take,
   input  logic [2:0]           command,
   input  logic [31:0]          now,
   output pomo_pkg::rsp_type    result
);

   logic [26:0] work_ff, short_ff, long_ff, beep_ff;
   logic [3:0]  cyclen_ff;

   logic [1:0]  phase_ff, phase_in;
   logic        running_ff, running_in;
   logic        beeping_ff, beeping_in;
   logic [26:0] left_ff, left_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [31:0] alert_ff, alert_in;
   logic [3:0]  cyc_ff, cyc_in;
   logic [15:0] tot_ff, tot_in;

   logic [31:0] elapsed;
   logic        expired;
   logic [3:0]  cyc_inc;
   logic [1:0]  brk_now, brk_inc;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff   <= pomo_pkg::WORK_RST;
         short_ff  <= pomo_pkg::SHORT_RST;
         long_ff   <= pomo_pkg::LONG_RST;
         beep_ff   <= pomo_pkg::BEEP_RST;
         cyclen_ff <= pomo_pkg::CYCLE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            pomo_pkg::REG_WORK:  work_ff   <= csr_wdata;
            pomo_pkg::REG_SHORT: short_ff  <= csr_wdata;
            pomo_pkg::REG_LONG:  long_ff   <= csr_wdata;
            pomo_pkg::REG_BEEP:  beep_ff   <= csr_wdata;
            pomo_pkg::REG_CYCLE: cyclen_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Elapsed time and expiry compare
   assign elapsed = now - stamp_ff;
   assign expired = elapsed >= {5'd0, left_ff};
   assign cyc_inc = (cyc_ff != pomo_pkg::CYC_MAX) ? cyc_ff + 4'd1 : cyc_ff;
   // Break chosen after a work phase, with the count as it stands or bumped
   assign brk_now = (cyc_ff  >= cyclen_ff) ? pomo_pkg::PH_LONG : pomo_pkg::PH_SHORT;
   assign brk_inc = (cyc_inc >= cyclen_ff) ? pomo_pkg::PH_LONG : pomo_pkg::PH_SHORT;

   // Next state for the command in flight
   always_comb begin
      phase_in   = phase_ff;
      running_in = running_ff;
      beeping_in = beeping_ff;
      left_in    = left_ff;
      stamp_in   = stamp_ff;
      alert_in   = alert_ff;
      cyc_in     = cyc_ff;
      tot_in     = tot_ff;
      case (command)
         pomo_pkg::CMD_TICK: begin
            if (!beeping_ff) begin
               stamp_in = now;
               if (phase_ff != pomo_pkg::PH_IDLE && running_ff) begin
                  if (expired) begin
                     left_in    = '0;
                     running_in = 1'b0;
                     beeping_in = 1'b1;
                     alert_in   = now + {5'd0, beep_ff};
                  end else begin
                     left_in = left_ff - elapsed[26:0];
                  end
               end
            end
         end
         pomo_pkg::CMD_TOGGLE: begin
            if (!beeping_ff) begin
               if (phase_ff == pomo_pkg::PH_IDLE) begin
                  phase_in   = pomo_pkg::PH_WORK;
                  left_in    = work_ff;
                  running_in = 1'b1;
                  stamp_in   = now;
               end else begin
                  running_in = !running_ff;
                  if (!running_ff) stamp_in = now;
               end
            end
         end
         pomo_pkg::CMD_SKIP: begin
            beeping_in = 1'b0;
            alert_in   = '0;
            running_in = 1'b1;
            stamp_in   = now;
            if (phase_ff == pomo_pkg::PH_WORK) begin
               phase_in = brk_now;
               left_in  = (brk_now == pomo_pkg::PH_LONG) ? long_ff : short_ff;
            end else begin
               if (phase_ff == pomo_pkg::PH_LONG) cyc_in = '0;
               phase_in = pomo_pkg::PH_WORK;
               left_in  = work_ff;
            end
         end
         pomo_pkg::CMD_FINISH: begin
            if (beeping_ff) begin
               beeping_in = 1'b0;
               alert_in   = '0;
               if (phase_ff == pomo_pkg::PH_WORK) begin
                  cyc_in     = cyc_inc;
                  tot_in     = (tot_ff != pomo_pkg::TOT_MAX) ? tot_ff + 16'd1 : tot_ff;
                  phase_in   = brk_inc;
                  left_in    = (brk_inc == pomo_pkg::PH_LONG) ? long_ff : short_ff;
                  running_in = 1'b1;
                  stamp_in   = now;
               end else if (phase_ff != pomo_pkg::PH_IDLE) begin
                  if (phase_ff == pomo_pkg::PH_LONG) cyc_in = '0;
                  phase_in   = pomo_pkg::PH_WORK;
                  left_in    = work_ff;
                  running_in = 1'b1;
                  stamp_in   = now;
               end
            end
         end
         pomo_pkg::CMD_PAUSE: begin
            running_in = 1'b0;
            stamp_in   = '0;
         end
         pomo_pkg::CMD_RESET: begin
            phase_in   = pomo_pkg::PH_IDLE;
            running_in = 1'b0;
            beeping_in = 1'b0;
            left_in    = work_ff;
            cyc_in     = '0;
            tot_in     = '0;
            alert_in   = '0;
         end
         default: ;
      endcase
   end

   // Advance state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pomo_pkg::PH_IDLE;
         running_ff <= 1'b0;
         beeping_ff <= 1'b0;
         left_ff    <= pomo_pkg::WORK_RST;
         stamp_ff   <= '0;
         alert_ff   <= '0;
         cyc_ff     <= '0;
         tot_ff     <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         running_ff <= running_in;
         beeping_ff <= beeping_in;
         left_ff    <= left_in;
         stamp_ff   <= stamp_in;
         alert_ff   <= alert_in;
         cyc_ff     <= cyc_in;
         tot_ff     <= tot_in;
      end
   end

   // Result is the state after the command
   always_comb begin
      result.phase         = phase_in;
      result.running       = running_in;
      result.beeping       = beeping_in;
      result.remaining_ms  = left_in;
      result.done_in_cycle = cyc_in;
      result.done_total    = tot_in;
      result.alert_end_ms  = beeping_in ? alert_in : 32'd0;
   end

`ifndef NO_ASSERTIONS
   // An alert always means the countdown has stopped at zero
   a_beep_stopped: assert property (@(posedge clock) disable iff (reset)
      beeping_ff |-> (!running_ff && left_ff == 27'd0))
      else $error("beeping while running or with time left");

   // A beeping timer is never idle
   a_beep_phase: assert property (@(posedge clock) disable iff (reset)
      beeping_ff |-> (phase_ff != pomo_pkg::PH_IDLE))
      else $error("beeping in idle phase");

   // Total count never drops except through the reset command
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      (take && command != pomo_pkg::CMD_RESET) |=> (tot_ff >= $past(tot_ff)))
      else $error("total count went down");
`endif

endmodule

>>> hdl/pomo_skid.sv
// Two-entry result register: output stage plus skid stage.
module pomo_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pomo_pkg::rsp_type    push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output pomo_pkg::rsp_type    out_data
);

   logic              main_valid_ff, skid_valid_ff;
   pomo_pkg::rsp_type main_ff, skid_ff;
   logic              pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Hold control state for both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (main_valid_ff && !pop) skid_valid_ff <= 1'b1;
         else main_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Move payload: skid drains first, new transfer lands where there is room
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) main_ff <= skid_ff;
      end else if (push) begin
         if (main_valid_ff && !pop) skid_ff <= push_data;
         else main_ff <= push_data;
      end
   end

endmodule

>>> hdl/pomodoro_phase_timer.sv
// The result of an input transfer is registered in the output buffer and driven from there onto the rsp_ channel.
// Throughput: one command per cycle while req_stall is low; state updates in a single combinational pass.
// A two-entry output buffer keeps input flowing for one result while rsp_stall is high.
// Reset (synchronous, active high): idle phase, counts cleared, registers at defaults.
// No clearing pass; the block takes commands as soon as reset is released.
module pomodoro_phase_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [26:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_phase,
   output logic        rsp_running,
   output logic        rsp_beeping,
   output logic [26:0] rsp_remaining_ms,
   output logic [3:0]  rsp_done_in_cycle,
   output logic [15:0] rsp_done_total,
   output logic [31:0] rsp_alert_end_ms
);

   logic              take;
   logic              full;
   pomo_pkg::rsp_type next_rsp, out_rsp;

   assign req_stall = full;
   assign take      = req_valid && !full;

   pomo_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .command   (req_command),
      .now       (req_now),
      .result    (next_rsp)
   );

   pomo_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (next_rsp),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   assign rsp_phase         = out_rsp.phase;
   assign rsp_running       = out_rsp.running;
   assign rsp_beeping       = out_rsp.beeping;
   assign rsp_remaining_ms  = out_rsp.remaining_ms;
   assign rsp_done_in_cycle = out_rsp.done_in_cycle;
   assign rsp_done_total    = out_rsp.done_total;
   assign rsp_alert_end_ms  = out_rsp.alert_end_ms;

endmodule
